[design/chi_pkg.sv]
// Shared types, constants and helpers for the cubic Hermite interpolator.
package chi_pkg;

    // Field widths and fixed-point format
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int FRAC_BITS = 16;

    // Wide intermediate format: values are kept within +-2^61
    localparam int WIDE_W = 63;
    localparam int MAG_W  = WIDE_W - 1;
    localparam int HALF_W = MAG_W / 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam int ACC_W  = 64;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam acc_t  ACC_LIM   = 64'sh2000_0000_0000_0000;
    localparam wide_t WIDE_LIM  = wide_t'(ACC_LIM);
    localparam wide_t ONE       = wide_t'(1) <<< FRAC_BITS;
    localparam wide_t THREE     = wide_t'(3) <<< FRAC_BITS;
    localparam acc_t  OUT_MAX   = 64'sd2147483647;
    localparam acc_t  OUT_MIN   = -64'sd2147483648;

    // Pipelined multiplier: sign/magnitude, partial products, sum, round
    localparam int MUL_LAT    = 4;
    localparam int MUL_UNITS  = 4;
    localparam int MUL_LEVELS = 4;

    // Pipelined restoring divider
    localparam int DEN_W      = DATA_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = 13;
    localparam int DIV_W      = DIV_STEP * DIV_STAGES;

    // Input register, difference stage, divider set-up stage, divider,
    // weight stage, four multiply levels, three summing stages
    localparam int PIPE_LAT = 3 + DIV_STAGES + 1 + MUL_LEVELS * MUL_LAT + 3;

    // Register map
    localparam int  PADDR_W  = 3;
    localparam logic REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_FULL   = 2'd1,
        MODE_LEFT   = 2'd2,
        MODE_RIGHT  = 2'd3
    } mode_t;

    // Per-request context carried alongside the datapath
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic                     last;
        logic                     eq;
        logic                     qneg;
        logic signed [DATA_W-1:0] fa;
        logic signed [DATA_W-1:0] fb;
        logic signed [DATA_W-1:0] dfa;
        logic signed [DATA_W-1:0] dfb;
        wide_t                    d;
        wide_t                    fbfa;
        wide_t                    tt;
        wide_t                    v;
        wide_t                    w;
        wide_t                    r0;
        wide_t                    r1;
        wide_t                    r2;
        wide_t                    r3;
    } ctx_t;

    // Saturate to +-2^61
    function automatic acc_t clampw(input acc_t x);
        acc_t y;
        y = x;
        if (x > ACC_LIM) begin
            y = ACC_LIM;
        end else if (x < -ACC_LIM) begin
            y = -ACC_LIM;
        end
        return y;
    endfunction

endpackage

[design/cubic_hermite_interpolator_unit.sv]
// Cubic Hermite interpolator: top level with register port and pipeline.
//
// One vector element is taken per clock: busy stays low, so a request is
// accepted whenever start is high. Each result appears for a single cycle
// with done high; the receiver cannot stall it. The pipeline depth is set
// by the 13-stage restoring divider for the normalised time and the four
// chained levels of pipelined multipliers. interp_mode sits at byte
// address 0 and should only be written while no request is in flight.
module cubic_hermite_interpolator_unit import chi_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] left_time,
    input  logic signed [DATA_W-1:0] right_time,
    input  logic signed [DATA_W-1:0] query_time,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] left_slope,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic signed [DATA_W-1:0] right_slope,
    input  logic [IDX_W-1:0]         element_index,
    input  logic                     last_element,
    output logic                     done,
    output logic [IDX_W-1:0]         out_index,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     out_last,
    output logic                     saturated,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    mode_t               mode_reg, mode_next;
    logic [PIPE_LAT-1:0] vld_reg, vld_next;
    logic                accept;

    ctx_t                     ctx_s0_reg, ctx_s0_next;
    logic signed [DATA_W-1:0] ta_s0_reg, tb_s0_reg, tq_s0_reg;
    ctx_t                     ctx_s1_reg, ctx_s1_next;
    logic signed [DATA_W:0]   s_s1_reg, s_s1_next;
    ctx_t                     ctx_s2_reg, ctx_s2_next;
    logic [DIV_W-1:0]         num_s2_reg, num_s2_next;
    logic [DEN_W-1:0]         den_s2_reg, den_s2_next;
    ctx_t                     ctx_div_reg [DIV_STAGES];
    logic [DIV_W-1:0]         quo;
    ctx_t                     ctx_s3_reg, ctx_s3_next;

    ctx_t  ctx_lv_reg [MUL_LEVELS][MUL_LAT];
    ctx_t  lv_in      [MUL_LEVELS];
    ctx_t  lv_out     [MUL_LEVELS];
    wide_t op_a       [MUL_LEVELS][MUL_UNITS];
    wide_t op_b       [MUL_LEVELS][MUL_UNITS];
    wide_t prod       [MUL_LEVELS][MUL_UNITS];

    ctx_t ctx_f1_reg, ctx_f2_reg;
    acc_t acc_f1_reg, acc_f1_next;
    acc_t acc_f2_reg, acc_f2_next;

    logic [IDX_W-1:0]         out_index_reg, out_index_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;
    logic                     saturated_reg, saturated_next;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? DATA_W'(mode_reg) : '0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_MODE))
        begin
            mode_next = mode_t'(pwdata[1:0]);
        end
    end

    // Request valid bits
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[PIPE_LAT-2:0], accept};
    assign done     = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FULL;
            vld_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            vld_reg  <= vld_next;
        end
    end

    // Stage 0: input register
    always_comb
    begin
        ctx_s0_next      = '0;
        ctx_s0_next.idx  = element_index;
        ctx_s0_next.last = last_element;
        ctx_s0_next.fa   = left_value;
        ctx_s0_next.fb   = right_value;
        ctx_s0_next.dfa  = left_slope;
        ctx_s0_next.dfb  = right_slope;
    end

    always_ff @(posedge clk)
    begin
        ctx_s0_reg <= ctx_s0_next;
        ta_s0_reg  <= left_time;
        tb_s0_reg  <= right_time;
        tq_s0_reg  <= query_time;
    end

    // Stage 1: interval, offset and value difference
    always_comb
    begin
        ctx_s1_next      = ctx_s0_reg;
        ctx_s1_next.d    = wide_t'(tb_s0_reg) - wide_t'(ta_s0_reg);
        ctx_s1_next.eq   = (tb_s0_reg == ta_s0_reg);
        ctx_s1_next.fbfa = wide_t'(ctx_s0_reg.fb) - wide_t'(ctx_s0_reg.fa);
        s_s1_next        = (DATA_W+1)'(tq_s0_reg) - (DATA_W+1)'(ta_s0_reg);
    end

    // Stage 2: magnitudes and rounded dividend
    always_comb
    begin
        logic signed [DATA_W:0] s_abs;
        wide_t                  d_abs;
        s_abs            = s_s1_reg[DATA_W] ? -s_s1_reg : s_s1_reg;
        d_abs            = ctx_s1_reg.d[WIDE_W-1] ? -ctx_s1_reg.d : ctx_s1_reg.d;
        ctx_s2_next      = ctx_s1_reg;
        ctx_s2_next.qneg = s_s1_reg[DATA_W] ^ ctx_s1_reg.d[WIDE_W-1];
        den_s2_next      = d_abs[DEN_W-1:0];
        num_s2_next      = (DIV_W'(s_abs[DATA_W-1:0]) << FRAC_BITS)
                         + DIV_W'(d_abs[DEN_W-1:1]);
    end

    always_ff @(posedge clk)
    begin
        ctx_s1_reg <= ctx_s1_next;
        s_s1_reg   <= s_s1_next;
        ctx_s2_reg <= ctx_s2_next;
        num_s2_reg <= num_s2_next;
        den_s2_reg <= den_s2_next;
    end

    // Normalised time tt = s / d
    chi_div u_div (
        .clk (clk),
        .num (num_s2_reg),
        .den (den_s2_reg),
        .quo (quo)
    );

    always_ff @(posedge clk)
    begin
        ctx_div_reg[0] <= ctx_s2_reg;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            ctx_div_reg[i] <= ctx_div_reg[i-1];
        end
    end

    // Stage 3: tt, v = 1 - tt, w = 3 - 2tt
    always_comb
    begin
        wide_t tt;
        tt             = ctx_div_reg[DIV_STAGES-1].qneg ? -wide_t'(quo) : wide_t'(quo);
        ctx_s3_next    = ctx_div_reg[DIV_STAGES-1];
        ctx_s3_next.tt = tt;
        ctx_s3_next.v  = ONE - tt;
        ctx_s3_next.w  = THREE - (tt <<< 1);
    end

    always_ff @(posedge clk)
    begin
        ctx_s3_reg <= ctx_s3_next;
    end

    // Multiply levels: context rides alongside, products land in r0..r3
    always_comb
    begin
        for (int l = 0; l < MUL_LEVELS; l++)
        begin
            lv_out[l]    = ctx_lv_reg[l][MUL_LAT-1];
            lv_out[l].r0 = prod[l][0];
            lv_out[l].r1 = prod[l][1];
            lv_out[l].r2 = prod[l][2];
            lv_out[l].r3 = prod[l][3];
            lv_in[l]     = (l == 0) ? ctx_s3_reg : lv_out[(l == 0) ? 0 : l - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MUL_LEVELS; l++)
        begin
            ctx_lv_reg[l][0] <= lv_in[l];
            for (int i = 1; i < MUL_LAT; i++)
            begin
                ctx_lv_reg[l][i] <= ctx_lv_reg[l][i-1];
            end
        end
    end

    genvar gl, gu;
    for (gl = 0; gl < MUL_LEVELS; gl++) begin : g_level
        for (gu = 0; gu < MUL_UNITS; gu++) begin : g_unit
            chi_mulq u_mul (
                .clk (clk),
                .a   (op_a[gl][gu]),
                .b   (op_b[gl][gu]),
                .p   (prod[gl][gu])
            );
        end
    end

    // Operand selection per level and mode; multiplying by ONE passes a value on
    always_comb
    begin
        ctx_t c;

        // Level 1: tt^2, tt*v, v^2, linear term
        c = lv_in[0];
        op_a[0][0] = c.tt;    op_b[0][0] = c.tt;
        op_a[0][1] = c.tt;    op_b[0][1] = c.v;
        op_a[0][2] = c.v;     op_b[0][2] = c.v;
        op_a[0][3] = c.fbfa;  op_b[0][3] = c.tt;

        // Level 2
        c = lv_in[1];
        op_a[1][2] = c.r0;    op_b[1][2] = c.v;
        op_a[1][3] = c.r3;    op_b[1][3] = ONE;
        unique case (mode_reg) inside
            MODE_FULL:
            begin
                op_a[1][0] = c.r0;    op_b[1][0] = c.w;
                op_a[1][1] = c.tt;    op_b[1][1] = c.r2;
            end
            MODE_RIGHT:
            begin
                op_a[1][0] = -c.fbfa; op_b[1][0] = c.r2;
                op_a[1][1] = c.d;     op_b[1][1] = c.r1;
            end
            MODE_LEFT, MODE_LINEAR:
            begin
                op_a[1][0] = c.fbfa;  op_b[1][0] = c.r0;
                op_a[1][1] = c.d;     op_b[1][1] = c.r1;
            end
        endcase

        // Level 3
        c = lv_in[2];
        op_a[2][2] = c.d;     op_b[2][2] = c.r2;
        op_a[2][3] = c.r3;    op_b[2][3] = ONE;
        unique case (mode_reg) inside
            MODE_FULL:
            begin
                op_a[2][0] = c.fbfa;            op_b[2][0] = c.r0;
                op_a[2][1] = c.d;               op_b[2][1] = c.r1;
            end
            MODE_RIGHT:
            begin
                op_a[2][0] = c.r0;              op_b[2][0] = ONE;
                op_a[2][1] = -wide_t'(c.dfb);   op_b[2][1] = c.r1;
            end
            MODE_LEFT, MODE_LINEAR:
            begin
                op_a[2][0] = c.r0;              op_b[2][0] = ONE;
                op_a[2][1] = wide_t'(c.dfa);    op_b[2][1] = c.r1;
            end
        endcase

        // Level 4
        c = lv_in[3];
        op_a[3][0] = c.r0;               op_b[3][0] = ONE;
        op_a[3][2] = -wide_t'(c.dfb);    op_b[3][2] = c.r2;
        op_a[3][3] = c.r3;               op_b[3][3] = ONE;
        if (mode_reg == MODE_FULL)
        begin
            op_a[3][1] = wide_t'(c.dfa); op_b[3][1] = c.r1;
        end
        else
        begin
            op_a[3][1] = c.r1;           op_b[3][1] = ONE;
        end
    end

    // Summing stage 1: base value plus value term
    always_comb
    begin
        ctx_t c;
        acc_t base;
        acc_t x;
        c           = lv_out[MUL_LEVELS-1];
        base        = (mode_reg == MODE_RIGHT) ? acc_t'(c.fb) : acc_t'(c.fa);
        x           = (mode_reg == MODE_LINEAR) ? acc_t'(c.r3) : acc_t'(c.r0);
        acc_f1_next = clampw(base + x);
    end

    // Summing stage 2: left or right slope term
    always_comb
    begin
        acc_t y;
        y           = (mode_reg == MODE_LINEAR) ? '0 : acc_t'(ctx_f1_reg.r1);
        acc_f2_next = clampw(acc_f1_reg + y);
    end

    // Summing stage 3: right slope term of the full form, clip to 32 bits
    always_comb
    begin
        acc_t z;
        acc_t sum;
        z              = (mode_reg == MODE_FULL) ? acc_t'(ctx_f2_reg.r2) : '0;
        sum            = acc_f2_reg + z;
        saturated_next = 1'b0;
        if (sum > OUT_MAX)
        begin
            sum            = OUT_MAX;
            saturated_next = 1'b1;
        end
        else if (sum < OUT_MIN)
        begin
            sum            = OUT_MIN;
            saturated_next = 1'b1;
        end
        out_value_next = sum[DATA_W-1:0];
        // equal support times give the right value
        if (ctx_f2_reg.eq)
        begin
            out_value_next = ctx_f2_reg.fb;
            saturated_next = 1'b0;
        end
        out_index_next = ctx_f2_reg.idx;
        out_last_next  = ctx_f2_reg.last;
    end

    always_ff @(posedge clk)
    begin
        ctx_f1_reg    <= lv_out[MUL_LEVELS-1];
        acc_f1_reg    <= acc_f1_next;
        ctx_f2_reg    <= ctx_f1_reg;
        acc_f2_reg    <= acc_f2_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        saturated_reg <= saturated_next;
    end

    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign saturated = saturated_reg;

    // Checks
    a_done_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without a matching request");

    a_tag_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_index == $past(element_index, PIPE_LAT))
              && (out_last == $past(last_element, PIPE_LAT)))
        else $error("index or last marker out of step with the request");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_value == 32'sh7fff_ffff)
                             || (out_value == 32'sh8000_0000))
        else $error("saturation flag set but value not at a rail");

endmodule

[design/chi_div.sv]
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module chi_div import chi_pkg::*; (
    input  logic             clk,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    logic [DIV_W-1:0] nq_reg   [DIV_STAGES];
    logic [DIV_W-1:0] nq_next  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_next [DIV_STAGES];

    genvar k;
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
        // Shift dividend bits into the remainder, keep quotient bits at the bottom
        always_comb
        begin
            logic [DEN_W:0]   trial;
            logic [DEN_W-1:0] rem;
            logic [DIV_W-1:0] nq;
            logic [DEN_W-1:0] dv;
            if (k == 0)
            begin
                rem = '0;
                nq  = num;
                dv  = den;
            end
            else
            begin
                rem = rem_reg[(k == 0) ? 0 : k - 1];
                nq  = nq_reg[(k == 0) ? 0 : k - 1];
                dv  = den_reg[(k == 0) ? 0 : k - 1];
            end
            for (int j = 0; j < DIV_STEP; j++)
            begin
                trial = {rem, nq[DIV_W-1]};
                nq    = {nq[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, dv})
                begin
                    trial = trial - {1'b0, dv};
                    nq[0] = 1'b1;
                end
                rem = trial[DEN_W-1:0];
            end
            rem_next[k] = rem;
            nq_next[k]  = nq;
            den_next[k] = dv;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next[k];
            nq_reg[k]  <= nq_next[k];
            den_reg[k] <= den_next[k];
        end
    end

    assign quo = nq_reg[DIV_STAGES-1];

endmodule

[design/chi_mulq.sv]
// Pipelined fixed-point multiply, rounded half away from zero, saturated.
module chi_mulq import chi_pkg::*; (
    input  logic  clk,
    input  wide_t a,
    input  wide_t b,
    output wide_t p
);

    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [MAG_W-1:0]  ma_reg, mb_reg;
    logic [MAG_W-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PROD_W-1:0] sum_reg;
    wide_t             p_reg;
    logic [PROD_W-1:0] sh;
    logic [MAG_W-1:0]  res;
    wide_t             p_next;

    function automatic logic [MAG_W-1:0] mag(input wide_t x);
        wide_t n;
        n = x[WIDE_W-1] ? -x : x;
        return n[MAG_W-1:0];
    endfunction

    // Stage 1: sign and magnitudes
    always_ff @(posedge clk)
    begin
        neg1_reg <= a[WIDE_W-1] ^ b[WIDE_W-1];
        ma_reg   <= mag(a);
        mb_reg   <= mag(b);
    end

    // Stage 2: four half-width partial products
    always_ff @(posedge clk)
    begin
        neg2_reg <= neg1_reg;
        p00_reg  <= MAG_W'(ma_reg[HALF_W-1:0]) * MAG_W'(mb_reg[HALF_W-1:0]);
        p01_reg  <= MAG_W'(ma_reg[HALF_W-1:0]) * MAG_W'(mb_reg[MAG_W-1:HALF_W]);
        p10_reg  <= MAG_W'(ma_reg[MAG_W-1:HALF_W]) * MAG_W'(mb_reg[HALF_W-1:0]);
        p11_reg  <= MAG_W'(ma_reg[MAG_W-1:HALF_W]) * MAG_W'(mb_reg[MAG_W-1:HALF_W]);
    end

    // Stage 3: full product plus rounding constant
    always_ff @(posedge clk)
    begin
        neg3_reg <= neg2_reg;
        sum_reg  <= (PROD_W'(p11_reg) << (2 * HALF_W))
                  + (PROD_W'(p01_reg) << HALF_W)
                  + (PROD_W'(p10_reg) << HALF_W)
                  + PROD_W'(p00_reg)
                  + (PROD_W'(1) << (FRAC_BITS - 1));
    end

    // Stage 4: drop fraction bits, clip, restore sign
    always_comb
    begin
        sh = sum_reg >> FRAC_BITS;
        if (sh > PROD_W'(WIDE_LIM))
        begin
            res = WIDE_LIM[MAG_W-1:0];
        end
        else
        begin
            res = sh[MAG_W-1:0];
        end
        p_next = neg3_reg ? -wide_t'(res) : wide_t'(res);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[verif/cubic_hermite_interpolator_unit_chk.sv]
// Checker for the cubic Hermite interpolator: predicts each result and compares it.
`timescale 1ns / 100ps

module cubic_hermite_interpolator_unit_chk import chi_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] left_time,
    input  logic signed [DATA_W-1:0] right_time,
    input  logic signed [DATA_W-1:0] query_time,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] left_slope,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic signed [DATA_W-1:0] right_slope,
    input  logic [IDX_W-1:0]         element_index,
    input  logic                     last_element,
    input  logic                     done,
    input  logic [IDX_W-1:0]         out_index,
    input  logic signed [DATA_W-1:0] out_value,
    input  logic                     out_last,
    input  logic                     saturated,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    input  logic                     pready,
    output int                       mismatches,
    output int                       pending,
    output int                       checked
);

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     sat;
    } interp_res_t;

    localparam longint LIM   = 64'sd1 <<< 61;
    localparam longint UNITY = 64'sd1 <<< FRAC_BITS;

    interp_res_t interp_q[$];
    mode_t       cur_mode;

    function automatic longint lim61(longint x);
        if (x > LIM) return LIM;
        if (x < -LIM) return -LIM;
        return x;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return lim61(lim61(a) + lim61(b));
    endfunction

    // Q16.16 product, rounded half away from zero, magnitude capped at 2^61
    function automatic longint qmul(longint a, longint b);
        logic [127:0] ma, mb, p;
        logic         neg;
        longint       r;
        a   = lim61(a);
        b   = lim61(b);
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p > 128'(LIM)) p = 128'(LIM);
        r = longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    // Normalised time s/d in Q16.16, rounded half away from zero
    function automatic longint qdiv(longint s, longint d);
        logic [63:0] us, ud, q;
        us = ((s < 0) ? 64'(-s) : 64'(s)) << FRAC_BITS;
        ud = (d < 0) ? 64'(-d) : 64'(d);
        q  = (us + ud / 2) / ud;
        if (q > 64'(LIM)) q = 64'(LIM);
        return ((s < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic interp_res_t interpolate(mode_t m);
        interp_res_t r;
        longint ta, tb, tq, fa, dfa, fb, dfb, d, s, tt, v, tt2, w, acc;
        ta  = left_time;   tb  = right_time; tq = query_time;
        fa  = left_value;  dfa = left_slope;
        fb  = right_value; dfb = right_slope;
        d   = tb - ta;
        s   = tq - ta;
        if (d == 0) begin
            acc = fb;
        end else begin
            tt  = qdiv(s, d);
            v   = add_sat(UNITY, -tt);
            tt2 = qmul(tt, tt);
            case (m)
                MODE_LINEAR: acc = add_sat(fa, qmul(fb - fa, tt));
                MODE_LEFT:
                begin
                    acc = add_sat(fa, qmul(fb - fa, tt2));
                    acc = add_sat(acc, qmul(dfa, qmul(d, qmul(tt, v))));
                end
                MODE_RIGHT:
                begin
                    acc = add_sat(fb, qmul(fa - fb, qmul(v, v)));
                    acc = add_sat(acc, -qmul(dfb, qmul(d, qmul(tt, v))));
                end
                default:
                begin
                    w   = add_sat(3 * UNITY, -(2 * tt));
                    acc = add_sat(fa, qmul(fb - fa, qmul(tt2, w)));
                    acc = add_sat(acc, qmul(dfa, qmul(d, qmul(tt, qmul(v, v)))));
                    acc = add_sat(acc, -qmul(dfb, qmul(d, qmul(tt2, v))));
                end
            endcase
        end
        r.sat = 1'b0;
        if (acc > 64'sd2147483647) begin
            acc   = 64'sd2147483647;
            r.sat = 1'b1;
        end else if (acc < -64'sd2147483648) begin
            acc   = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = acc[31:0];
        r.idx   = element_index;
        r.last  = last_element;
        return r;
    endfunction

    assign pending = interp_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        interp_res_t exp_r;
        if (!rst_n) begin
            cur_mode   = MODE_FULL;
            mismatches = 0;
            checked    = 0;
            interp_q.delete();
        end else begin
            // compare the result leaving this cycle
            if (done) begin
                checked++;
                if (interp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result idx %0d with no request outstanding", out_index);
                end else begin
                    exp_r = interp_q.pop_front();
                    if (out_index !== exp_r.idx || out_value !== exp_r.value ||
                        out_last !== exp_r.last || saturated !== exp_r.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp idx %0d val %h last %b sat %b, got %0d %h %b %b",
                                     exp_r.idx, exp_r.value, exp_r.last, exp_r.sat,
                                     out_index, out_value, out_last, saturated);
                    end
                end
            end
            // predict for an accepted request under the mode now in force
            if (start && !busy)
                interp_q.push_back(interpolate(cur_mode));
            // register write
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_MODE)
                cur_mode = mode_t'(pwdata[1:0]);
        end
    end

endmodule

[verif/cubic_hermite_interpolator_unit_tb.sv]
// Testbench top for the cubic Hermite interpolator: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module cubic_hermite_interpolator_unit_tb import chi_pkg::*;;

    localparam int STALL_LIMIT = 4000;
    localparam int RAND_PER_MODE = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [DATA_W-1:0] left_time = '0, right_time = '0, query_time = '0;
    logic signed [DATA_W-1:0] left_value = '0, left_slope = '0;
    logic signed [DATA_W-1:0] right_value = '0, right_slope = '0;
    logic [IDX_W-1:0] element_index = '0;
    logic last_element = 1'b0;
    logic done;
    logic [IDX_W-1:0] out_index;
    logic signed [DATA_W-1:0] out_value;
    logic out_last, saturated;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    int mismatches, pending, checked;
    int requests = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    cubic_hermite_interpolator_unit dut (.*);
    cubic_hermite_interpolator_unit_chk chk (.*);

    // watchdog: cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("cubic_hermite_interpolator_unit test failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drive one request after a random gap, return once accepted
    task automatic send(input logic signed [DATA_W-1:0] ta, tb, tq, fa, dfa, fb, dfb);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 3) gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start         = 1'b1;
        left_time     = ta;
        right_time    = tb;
        query_time    = tq;
        left_value    = fa;
        left_slope    = dfa;
        right_value   = fb;
        right_slope   = dfb;
        element_index = IDX_W'($urandom_range(0, 1023));
        last_element  = 1'($urandom_range(0, 1));
        do @(posedge clk); while (busy);
        requests++;
    endtask

    // wait for the pipeline to empty, then let it settle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // random element: mostly realistic spans, sometimes raw 32-bit noise or equal times
    task automatic send_random();
        logic signed [DATA_W-1:0] ta, tb, tq, fa, dfa, fb, dfb;
        int span;
        ta  = $urandom;
        tb  = $urandom;
        tq  = $urandom;
        fa  = $urandom;
        dfa = $urandom;
        fb  = $urandom;
        dfb = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2:    tb = ta;
            default:
            begin
                span = $urandom_range(1, 1 << 20);
                ta   = $signed($urandom) >>> $urandom_range(1, 8);
                tb   = ta + (($urandom_range(0, 4) == 0) ? -span : span);
                tq   = ta + $signed($urandom_range(0, 3 * span)) - span;
                fa   = $signed($urandom) >>> $urandom_range(0, 12);
                fb   = $signed($urandom) >>> $urandom_range(0, 12);
                dfa  = $signed($urandom) >>> $urandom_range(0, 16);
                dfb  = $signed($urandom) >>> $urandom_range(0, 16);
            end
        endcase
        send(ta, tb, tq, fa, dfa, fb, dfb);
    endtask

    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q1   = 32'sh0001_0000;

    mode_t mode_seq[4] = '{MODE_LINEAR, MODE_RIGHT, MODE_LEFT, MODE_FULL};

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset mode (full Hermite) first
        send(0, Q1, Q1 / 2, 0, Q1, Q1, Q1);
        send(0, Q1, 0, Q1, 0, -Q1, 0);
        send(0, Q1, Q1, Q1, 0, -Q1, 0);
        send(Q1, Q1, 0, 5, 6, 123, 7);                 // equal times
        send(SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMIN); // equal times at extremes
        send(SMIN, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN);
        send(SMAX, SMIN, SMIN, SMAX, SMIN, SMIN, SMAX);
        send(0, 1, SMAX, SMAX, SMAX, SMIN, SMIN);       // deep extrapolation
        send(0, -1, SMIN, SMIN, SMAX, SMAX, SMIN);
        send(0, 3, 1, 0, 0, 32'sd2, 0);                 // rounding of tt
        send(-Q1, Q1, 3 * Q1, 0, Q1, Q1, -Q1);
        send(0, 32'sd3, 32'sd3, 32'sd1, 0, 32'sd1, 0);
        drain();

        // directed per mode, then random, extremes of the mode range included
        foreach (mode_seq[m])
        begin
            reg_write(3'd4, 32'h0000_0000);              // unmapped, ignored
            reg_write(3'd0, {30'h3fff_ffff, 2'(mode_seq[m])});
            send(0, Q1, Q1 / 4, Q1, Q1, 3 * Q1, -Q1);
            send(0, 1, SMIN, SMAX, SMIN, SMIN, SMAX);
            send(Q1, Q1, 0, SMAX, 0, SMIN, 0);
            repeat (RAND_PER_MODE) send_random();
            drain();
        end

        // back to reset value, with back-to-back bursts
        reg_write(3'd0, 32'(MODE_FULL));
        repeat (RAND_PER_MODE) send_random();
        drain();

        $display("%0d requests (directed and random) over all four modes, %0d results checked",
                 requests, checked);
        if (mismatches == 0 && pending == 0)
            $display("cubic_hermite_interpolator_unit test passed");
        else
            $display("cubic_hermite_interpolator_unit test failed");
        $finish;
    end

endmodule
